[rtl/core/gmam_pkg.sv]
`timescale 1ns / 1ps

package gmam_pkg;

    typedef enum logic [1:0] {
        MODE_BYTE   = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_ASSERT = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] ack_flag;
        logic              balloon_confirmed;
        logic              send_assert;
    } out_item_t;

    // line-end outcome handed from the scanner to the flag logic
    typedef struct packed {
        logic        ack_load;
        logic [7:0]  ack_value;
        logic        banner;
    } line_evt_t;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PERIOD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_FRESH  = 8'd1;

    localparam logic [15:0] PERIOD_RESET = 16'd4000;
    localparam logic [15:0] FRESH_RESET  = 16'd20000;

    localparam int          MIN_LINE_BYTES = 8;
    localparam int          ACK_PAT_LEN    = 12;
    localparam int          BANNER_PRE_LEN = 6;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_NUL   = 8'h00;
    localparam logic [7:0]  CH_P     = 8'h50;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_ONE   = 8'h31;
    localparam logic [7:0]  FLAG_NONE     = 8'hFF;
    localparam logic [7:0]  FLAG_ACCEPTED = 8'd3;

    // "PMTK001,886,"
    function automatic logic [7:0] ack_pattern(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h50;
            4'd1:    ch = 8'h4D;
            4'd2:    ch = 8'h54;
            4'd3:    ch = 8'h4B;
            4'd4:    ch = 8'h30;
            4'd5:    ch = 8'h30;
            4'd6:    ch = 8'h31;
            4'd7:    ch = 8'h2C;
            4'd8:    ch = 8'h38;
            4'd9:    ch = 8'h38;
            4'd10:   ch = 8'h36;
            4'd11:   ch = 8'h2C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "PMTK01"
    function automatic logic [7:0] banner_prefix(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h50;
            3'd1:    ch = 8'h4D;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h4B;
            3'd4:    ch = 8'h30;
            3'd5:    ch = 8'h31;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[rtl/core/gnss_mode_ack_monitor_core.sv]
`timescale 1ns / 1ps
// A result passes the input register, then the result register; it is held
// there while m_ready holds it back. Throughput: one item per cycle unless
// m_ready stalls; the line scan and tick counters update in one pass.
// Reset (aresetn low, synchronous) empties both stages, clears line state,
// sets the flag to -1 and loads the register defaults 4000 and 20000.
module gnss_mode_ack_monitor_core import gmam_pkg::*; #(
    parameter int LINE_BUFFER_BYTES = 96
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        m_valid_reg;
    out_item_t   m_item_reg, m_item_next;
    logic        advance, process;

    logic [15:0] period_reg, fresh_reg;
    logic [7:0]  flag_reg, flag_next;
    logic [15:0] age_reg, age_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic        restart_reg, restart_next;
    logic        send;
    line_evt_t   evt;

    assign advance   = !m_valid_reg || m_ready;
    assign process   = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign cfg_ready = 1'b1;

    gmam_line_scan #(
        .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (process),
        .item    (in_item_reg),
        .evt     (evt)
    );

    always_comb begin
        flag_next    = flag_reg;
        age_next     = age_reg;
        elapsed_next = elapsed_reg;
        restart_next = restart_reg;
        send         = 1'b0;

        unique case (in_item_reg.mode)
            MODE_BYTE: begin
                if (evt.ack_load) begin
                    flag_next = evt.ack_value;
                    if (evt.ack_value == FLAG_ACCEPTED) begin
                        age_next = '0;
                    end
                end
                if (evt.banner) begin
                    flag_next    = FLAG_NONE;
                    restart_next = 1'b1;
                end
            end
            MODE_TICK: begin
                if (age_reg != 16'hFFFF) begin
                    age_next = age_reg + 1'b1;
                end
                if (elapsed_reg != 16'hFFFF) begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
                if (restart_reg || elapsed_next >= period_reg) begin
                    restart_next = 1'b0;
                    elapsed_next = '0;
                    send         = 1'b1;
                end
            end
            MODE_ASSERT: begin
                elapsed_next = '0;
                send         = 1'b1;
            end
            default: ;
        endcase

        m_item_next.ack_flag          = flag_next;
        m_item_next.balloon_confirmed = (flag_next == FLAG_ACCEPTED) && (age_next < fresh_reg);
        m_item_next.send_assert       = send;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            period_reg   <= PERIOD_RESET;
            fresh_reg    <= FRESH_RESET;
            flag_reg     <= FLAG_NONE;
            age_reg      <= '0;
            elapsed_reg  <= '0;
            restart_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
            if (process) begin
                flag_reg    <= flag_next;
                age_reg     <= age_next;
                elapsed_reg <= elapsed_next;
                restart_reg <= restart_next;
            end
            if (cfg_valid) begin
                if (cfg_index == CFG_IDX_PERIOD) begin
                    period_reg <= cfg_data;
                end else if (cfg_index == CFG_IDX_FRESH) begin
                    fresh_reg <= cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (process) begin
            m_item_reg <= m_item_next;
        end
    end

endmodule

[rtl/core/gmam_line_scan.sv]
`timescale 1ns / 1ps

module gmam_line_scan import gmam_pkg::*; #(
    parameter int LINE_BUFFER_BYTES = 96
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  in_item_t   item,
    output line_evt_t  evt
);

    localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BUFFER_BYTES - 1);
    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(MIN_LINE_BYTES);

    logic [LEN_W-1:0] len_reg, len_next;
    logic             ended_reg, ended_next;
    logic [3:0]       ack_prog_reg, ack_prog_next;
    logic [1:0]       cap_phase_reg, cap_phase_next;
    logic [7:0]       cap_char_reg, cap_char_next;
    logic [2:0]       ban_prog_reg, ban_prog_next;
    logic             ban_found_reg, ban_found_next;

    logic [7:0] c;
    logic       is_eol;
    logic [3:0] p;
    logic [2:0] b;

    assign c      = item.rx_byte;
    assign is_eol = (c == CH_LF) || (c == CH_CR);

    always_comb begin
        len_next       = len_reg;
        ended_next     = ended_reg;
        ack_prog_next  = ack_prog_reg;
        cap_phase_next = cap_phase_reg;
        cap_char_next  = cap_char_reg;
        ban_prog_next  = ban_prog_reg;
        ban_found_next = ban_found_reg;
        p              = ack_prog_reg;
        b              = ban_prog_reg;
        evt            = '0;

        if (item.mode == MODE_BYTE) begin
            if (is_eol) begin
                if (len_reg >= LEN_MIN) begin
                    evt.ack_load  = (cap_phase_reg != 2'd0);
                    evt.ack_value = ((cap_phase_reg == 2'd2) ? cap_char_reg : CH_NUL) - CH_ZERO;
                    evt.banner    = ban_found_reg;
                end
                len_next       = '0;
                ended_next     = 1'b0;
                ack_prog_next  = '0;
                cap_phase_next = '0;
                cap_char_next  = '0;
                ban_prog_next  = '0;
                ban_found_next = 1'b0;
            end else if (len_reg < LEN_MAX) begin
                len_next = len_reg + 1'b1;
                if (!ended_reg) begin
                    if (c == CH_NUL) begin
                        ended_next = 1'b1;
                        if (cap_phase_reg == 2'd1) begin
                            cap_char_next  = CH_NUL;
                            cap_phase_next = 2'd2;
                        end
                    end else begin
                        // acknowledge search, then capture of the following byte
                        if (cap_phase_reg == 2'd1) begin
                            cap_char_next  = c;
                            cap_phase_next = 2'd2;
                        end else if (cap_phase_reg == 2'd0) begin
                            if (p < 4'(ACK_PAT_LEN) && c == ack_pattern(p)) begin
                                p = p + 1'b1;
                            end else begin
                                p = (c == CH_P) ? 4'd1 : 4'd0;
                            end
                            if (p >= 4'(ACK_PAT_LEN)) begin
                                cap_phase_next = 2'd1;
                                p = '0;
                            end
                            ack_prog_next = p;
                        end
                        // restart banner: prefix then '0' or '1'
                        if (!ban_found_reg) begin
                            if (b >= 3'(BANNER_PRE_LEN)) begin
                                if (c == CH_ZERO || c == CH_ONE) begin
                                    ban_found_next = 1'b1;
                                    b = '0;
                                end else begin
                                    b = (c == CH_P) ? 3'd1 : 3'd0;
                                end
                            end else if (c == banner_prefix(b)) begin
                                b = b + 1'b1;
                            end else begin
                                b = (c == CH_P) ? 3'd1 : 3'd0;
                            end
                            ban_prog_next = b;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            ended_reg     <= 1'b0;
            ack_prog_reg  <= '0;
            cap_phase_reg <= '0;
            cap_char_reg  <= '0;
            ban_prog_reg  <= '0;
            ban_found_reg <= 1'b0;
        end else if (advance) begin
            len_reg       <= len_next;
            ended_reg     <= ended_next;
            ack_prog_reg  <= ack_prog_next;
            cap_phase_reg <= cap_phase_next;
            cap_char_reg  <= cap_char_next;
            ban_prog_reg  <= ban_prog_next;
            ban_found_reg <= ban_found_next;
        end
    end

endmodule

[rtl/core/gmam_checker.sv]
`timescale 1ns / 1ps

module gmam_checker import gmam_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // confirmation only ever reported with an accepted flag
    a_confirm_needs_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.balloon_confirmed |-> m_item.ack_flag == 8'sd3)
        else $error("balloon_confirmed with ack_flag other than 3");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result transaction changed");

endmodule

bind gnss_mode_ack_monitor_core gmam_checker u_gmam_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

[verif/tb_gnss_mode_ack_monitor_core.sv]
`timescale 1ns / 1ps

module tb_gnss_mode_ack_monitor_core;
    import gmam_pkg::*;

    localparam int LINE_KEEP      = 95;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 5000;

    // "PMTK001,886," and "PMTK01", first character in the top byte
    localparam logic [8*12-1:0] ACK_TEXT    = "PMTK001,886,";
    localparam logic [8*6-1:0]  BANNER_TEXT = "PMTK01";

    typedef enum logic [1:0] {
        CAP_IDLE  = 2'd0,
        CAP_ARMED = 2'd1,
        CAP_HELD  = 2'd2
    } capture_e;

    typedef enum int {
        LINE_ACK    = 0,
        LINE_BANNER = 1,
        LINE_BOTH   = 2,
        LINE_LONG   = 3,
        LINE_SHORT  = 4,
        LINE_NOISE  = 5
    } line_kind_e;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_item    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    gnss_mode_ack_monitor_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // monitor state mirror
    logic [15:0] period_cfg;
    logic [15:0] fresh_cfg;
    logic [6:0]  ln_len;
    logic        ln_ended;
    logic [3:0]  ack_prog;
    capture_e    cap_phase;
    logic [7:0]  cap_char;
    logic [2:0]  ban_prog;
    logic        ban_found;
    logic [7:0]  flag_q;
    logic [15:0] ack_age_q;
    logic [15:0] elapsed_q;
    logic        restart_q;

    out_item_t   pending_results[$];
    logic [7:0]  line_bytes[$];
    int          error_count;
    int          items_sent;
    int          quiet_cycles;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          side_item_pct;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_line_state();
        ln_len    = '0;
        ln_ended  = 1'b0;
        ack_prog  = '0;
        cap_phase = CAP_IDLE;
        cap_char  = '0;
        ban_prog  = '0;
        ban_found = 1'b0;
    endfunction

    function automatic void reset_monitor_state();
        period_cfg = PERIOD_RESET;
        fresh_cfg  = FRESH_RESET;
        clear_line_state();
        flag_q    = FLAG_NONE;
        ack_age_q = '0;
        elapsed_q = '0;
        restart_q = 1'b0;
    endfunction

    function automatic void close_line();
        if (ln_len >= MIN_LINE_BYTES) begin
            if (cap_phase != CAP_IDLE) begin
                flag_q = ((cap_phase == CAP_HELD) ? cap_char : CH_NUL) - CH_ZERO;
                if (flag_q == FLAG_ACCEPTED) ack_age_q = '0;
            end
            if (ban_found) begin
                flag_q    = FLAG_NONE;
                restart_q = 1'b1;
            end
        end
        clear_line_state();
    endfunction

    function automatic void scan_text_byte(input logic [7:0] ch);
        logic [3:0] p;
        logic [2:0] b;
        if (cap_phase == CAP_ARMED) begin
            cap_char  = ch;
            cap_phase = CAP_HELD;
        end else if (cap_phase == CAP_IDLE) begin
            p = ack_prog;
            if (p < 12 && ch == ACK_TEXT[8*(11-p) +: 8]) p = p + 1'b1;
            else p = (ch == CH_P) ? 4'd1 : 4'd0;
            if (p >= 12) begin
                cap_phase = CAP_ARMED;
                p = '0;
            end
            ack_prog = p;
        end
        if (!ban_found) begin
            b = ban_prog;
            if (b >= 6) begin
                if (ch == CH_ZERO || ch == CH_ONE) begin
                    ban_found = 1'b1;
                    b = '0;
                end else begin
                    b = (ch == CH_P) ? 3'd1 : 3'd0;
                end
            end else if (ch == BANNER_TEXT[8*(5-b) +: 8]) begin
                b = b + 1'b1;
            end else begin
                b = (ch == CH_P) ? 3'd1 : 3'd0;
            end
            ban_prog = b;
        end
    endfunction

    function automatic out_item_t predict_monitor(input in_item_t it);
        out_item_t res;
        logic      send;
        send = 1'b0;
        case (it.mode)
            MODE_BYTE: begin
                if (it.rx_byte == CH_LF || it.rx_byte == CH_CR) begin
                    close_line();
                end else if (ln_len < LINE_KEEP) begin
                    ln_len = ln_len + 1'b1;
                    if (!ln_ended) begin
                        if (it.rx_byte == CH_NUL) begin
                            ln_ended = 1'b1;
                            if (cap_phase == CAP_ARMED) begin
                                cap_char  = CH_NUL;
                                cap_phase = CAP_HELD;
                            end
                        end else begin
                            scan_text_byte(it.rx_byte);
                        end
                    end
                end
            end
            MODE_TICK: begin
                if (ack_age_q != 16'hFFFF) ack_age_q = ack_age_q + 1'b1;
                if (elapsed_q != 16'hFFFF) elapsed_q = elapsed_q + 1'b1;
                if (restart_q || elapsed_q >= period_cfg) begin
                    restart_q = 1'b0;
                    elapsed_q = '0;
                    send      = 1'b1;
                end
            end
            MODE_ASSERT: begin
                elapsed_q = '0;
                send      = 1'b1;
            end
            default: ;
        endcase
        res.ack_flag          = flag_q;
        res.balloon_confirmed = (flag_q == FLAG_ACCEPTED) && (ack_age_q < fresh_cfg);
        res.send_assert       = send;
        return res;
    endfunction

    // result checker
    always @(posedge aclk) begin
        out_item_t exp_res;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: got %h", $time, m_item);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_item.ack_flag !== exp_res.ack_flag) begin
                    $display("%0t: ack_flag expected %0d, got %0d",
                             $time, exp_res.ack_flag, m_item.ack_flag);
                    error_count++;
                end
                if (m_item.balloon_confirmed !== exp_res.balloon_confirmed) begin
                    $display("%0t: balloon_confirmed expected %b, got %b",
                             $time, exp_res.balloon_confirmed, m_item.balloon_confirmed);
                    error_count++;
                end
                if (m_item.send_assert !== exp_res.send_assert) begin
                    $display("%0t: send_assert expected %b, got %b",
                             $time, exp_res.send_assert, m_item.send_assert);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL gnss_mode_ack_monitor_core");
            $finish;
        end
    end

    // valid stays high after a transaction; it only drops on an idle cycle or in settle
    task automatic send_item(input in_item_t it);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(predict_monitor(it));
        items_sent++;
    endtask

    task automatic send_side_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            send_item(in_item_t'{mode: MODE_TICK, rx_byte: 8'($urandom_range(255))});
        else if (pick < 85)
            send_item(in_item_t'{mode: MODE_ASSERT, rx_byte: 8'($urandom_range(255))});
        else
            send_item(in_item_t'{mode: MODE_UNUSED, rx_byte: 8'($urandom_range(255))});
    endtask

    task automatic send_line_bytes();
        foreach (line_bytes[i]) begin
            if ($urandom_range(99) < side_item_pct) send_side_item();
            send_item(in_item_t'{mode: MODE_BYTE, rx_byte: line_bytes[i]});
        end
        line_bytes.delete();
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [15:0] period, input logic [15:0] fresh);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_PERIOD;
        cfg_data  <= period;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        period_cfg = period;
        cfg_index <= CFG_IDX_FRESH;
        cfg_data  <= fresh;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        fresh_cfg = fresh;
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endfunction

    // printable, with extra 'P' to stress pattern restarts
    function automatic logic [7:0] rand_printable();
        if ($urandom_range(7) == 0) return CH_P;
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic void add_printable(input int n);
        repeat (n) line_bytes.push_back(rand_printable());
    endfunction

    function automatic void add_ack_fragment();
        string ack_str;
        ack_str = "PMTK001,886,";
        add_text(ack_str.substr(0, $urandom_range(1, 11) - 1));
    endfunction

    function automatic void add_ack_body();
        int pick;
        if ($urandom_range(9) == 0) line_bytes.push_back(CH_NUL);
        add_text("PMTK001,886,");
        pick = $urandom_range(99);
        if (pick < 45) begin
            line_bytes.push_back(CH_ZERO + 8'd3);
        end else if (pick < 65) begin
            line_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
        end else if (pick < 80) begin
            line_bytes.push_back(rand_printable());
        end else if (pick < 90) begin
            line_bytes.push_back(CH_NUL);
        end else begin
            return;   // line ends right after the match
        end
        if ($urandom_range(4) == 0) add_text(",PMTK001,886,5");
        add_printable($urandom_range(5));
    endfunction

    function automatic void add_banner_body();
        add_text("PMTK01");
        if ($urandom_range(9) < 7) line_bytes.push_back(CH_ZERO + 8'($urandom_range(1)));
        else line_bytes.push_back(rand_printable());
        add_printable($urandom_range(6));
    endfunction

    function automatic void build_random_line(input line_kind_e focus);
        line_kind_e kind;
        string      src;
        int         n;
        int         target;
        kind = ($urandom_range(99) < 60) ? focus : line_kind_e'($urandom_range(5));
        case (kind)
            LINE_ACK: begin
                if ($urandom_range(1)) add_text("$");
                if ($urandom_range(3) == 0) add_ack_fragment();
                add_printable($urandom_range(3));
                add_ack_body();
            end
            LINE_BANNER: begin
                if ($urandom_range(1)) add_text("$");
                add_printable($urandom_range(2));
                add_banner_body();
            end
            LINE_BOTH: begin
                add_text("$");
                if ($urandom_range(1)) begin
                    add_ack_body();
                    add_banner_body();
                end else begin
                    add_banner_body();
                    add_ack_body();
                end
            end
            LINE_LONG: begin
                // plant an acknowledge around the point where the line is cut
                target = $urandom_range(88, 110);
                add_printable($urandom_range(74, 92));
                add_text("PMTK001,886,3");
                while (line_bytes.size() < target) line_bytes.push_back(rand_printable());
            end
            LINE_SHORT: begin
                if ($urandom_range(1)) src = "PMTK011,A";
                else src = "PMTK001,886,3";
                n   = $urandom_range(9);
                for (int i = 0; i < n; i++) line_bytes.push_back(src[i]);
                if (n > 0 && $urandom_range(3) == 0)
                    line_bytes[$urandom_range(n - 1)] = CH_NUL;
            end
            default: begin
                repeat ($urandom_range(1, 30)) line_bytes.push_back(8'($urandom_range(255)));
            end
        endcase
        case ($urandom_range(2))
            0: line_bytes.push_back(CH_CR);
            1: line_bytes.push_back(CH_LF);
            default: begin
                line_bytes.push_back(CH_CR);
                line_bytes.push_back(CH_LF);
            end
        endcase
    endfunction

    task automatic run_lines(input line_kind_e focus, input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            build_random_line(focus);
            send_line_bytes();
        end
    endtask

    task automatic test_directed_basics();
        settle();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        side_item_pct      = 0;
        add_text("PMTK001,886,3");
        line_bytes.push_back(CH_CR);
        send_line_bytes();
        send_item(in_item_t'{mode: MODE_TICK, rx_byte: 8'h00});
        send_item(in_item_t'{mode: MODE_ASSERT, rx_byte: 8'h00});
        send_item(in_item_t'{mode: MODE_UNUSED, rx_byte: 8'hFF});
        // restart banner; NUL still counts toward the minimum length
        add_text("PMTK011");
        line_bytes.push_back(CH_NUL);
        line_bytes.push_back(CH_LF);
        send_line_bytes();
        send_item(in_item_t'{mode: MODE_TICK, rx_byte: 8'h00});
    endtask

    task automatic test_ack_capture();
        settle();
        write_config(16'd1, 16'd6);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        side_item_pct      = 15;
        run_lines(LINE_ACK, 150);
    endtask

    task automatic test_restart_banner();
        settle();
        write_config(16'hFFFF, 16'hFFFF);
        sender_idle_pct    = 75;
        receiver_stall_pct = 0;
        side_item_pct      = 10;
        run_lines(LINE_BANNER, 60);
        run_lines(LINE_BOTH, 50);
    endtask

    task automatic test_line_limits();
        settle();
        write_config(16'd3, 16'd1);
        sender_idle_pct    = 0;
        receiver_stall_pct = 75;
        side_item_pct      = 5;
        run_lines(LINE_LONG, 80);
        run_lines(LINE_SHORT, 30);
        run_lines(LINE_NOISE, 30);
    endtask

    task automatic tick_burst(input int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                build_random_line(LINE_ACK);
                send_line_bytes();
            end else if (pick < 11) begin
                build_random_line(LINE_BANNER);
                send_line_bytes();
            end else begin
                send_side_item();
            end
        end
    endtask

    task automatic test_tick_pacing();
        settle();
        write_config(16'd0, 16'd4);
        sender_idle_pct    = 11;
        receiver_stall_pct = 11;
        side_item_pct      = 0;
        tick_burst(80);
        settle();
        write_config(16'd2, 16'd10);
        tick_burst(80);
    endtask

    initial begin
        error_count        = 0;
        items_sent         = 0;
        quiet_cycles       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        side_item_pct      = 0;
        reset_monitor_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_basics();
        test_ack_capture();
        test_restart_banner();
        test_line_limits();
        test_tick_pacing();

        settle();
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS gnss_mode_ack_monitor_core");
        end else begin
            $display("FAIL gnss_mode_ack_monitor_core");
        end
        $finish;
    end

endmodule
